@@ hdl/llls_pkg.sv @@
// ---------------------------------------------------------------------------
// llls_pkg: shared types and constants for the least-loaded list scheduler
// Field widths, machine count, step codes and the microcode ROM.
// ---------------------------------------------------------------------------
`default_nettype none

package llls_pkg;

   localparam int MAX_MACHINES = 8;
   localparam int MACH_IDX_W   = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
   localparam int MACH_CNT_W   = $clog2(MAX_MACHINES + 1);

   localparam int JOB_ID_W  = 16;
   localparam int PROC_W    = 16;
   localparam int TIME_W    = 32;
   localparam int WEIGHT_W  = 16;
   localparam int CFG_W     = 4;
   localparam int IDX_OUT_W = 3;
   localparam int TARD_W    = 48;
   localparam int TOTAL_W   = 64;

   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

   // sequencer program counter
   localparam int STEP_W = 3;
   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_WAIT = 3'd0;
   localparam step_type STEP_INIT = 3'd1;
   localparam step_type STEP_SCAN = 3'd2;
   localparam step_type STEP_ADD  = 3'd3;
   localparam step_type STEP_DIFF = 3'd4;
   localparam step_type STEP_MUL  = 3'd5;
   localparam step_type STEP_ACC  = 3'd6;
   localparam step_type STEP_OUT  = 3'd7;

   typedef enum logic [1:0] {
      JMP_NEVER,
      JMP_NO_REQ,
      JMP_SCAN_MORE,
      JMP_RSP_BUSY
   } jump_cond_type;

   typedef struct packed {
      logic          req_ready;
      logic          scan_init;
      logic          scan_step;
      logic          add_load;
      logic          diff;
      logic          mul;
      logic          acc;
      logic          out_load;
      jump_cond_type cond;
      step_type      target;
   } ctrl_word_type;

   // control store: jump to target when cond holds, else fall to the next step
   // (the last step wraps to the first)
   function automatic ctrl_word_type ucode_rom(input step_type step);
      ctrl_word_type w;
      w = '{default: '0, cond: JMP_NEVER, target: STEP_WAIT};
      case (step)
         STEP_WAIT: begin
            w.req_ready = 1'b1;
            w.cond      = JMP_NO_REQ;
            w.target    = STEP_WAIT;
         end
         STEP_INIT: w.scan_init = 1'b1;
         STEP_SCAN: begin
            w.scan_step = 1'b1;
            w.cond      = JMP_SCAN_MORE;
            w.target    = STEP_SCAN;
         end
         STEP_ADD:  w.add_load = 1'b1;
         STEP_DIFF: w.diff     = 1'b1;
         STEP_MUL:  w.mul      = 1'b1;
         STEP_ACC:  w.acc      = 1'b1;
         STEP_OUT: begin
            w.out_load = 1'b1;
            w.cond     = JMP_RSP_BUSY;
            w.target   = STEP_OUT;
         end
         default: w.cond = JMP_NEVER;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

@@ hdl/llls_ifs.sv @@
// ---------------------------------------------------------------------------
// llls_ifs: job request and placement response channels
// Valid/ready channels; a transaction completes when both are high.
// ---------------------------------------------------------------------------
`default_nettype none

interface llls_req_if;
   logic                          valid;
   logic                          ready;
   logic [llls_pkg::JOB_ID_W-1:0] job_id;
   logic [llls_pkg::PROC_W-1:0]   proc_time;
   logic [llls_pkg::TIME_W-1:0]   deadline;
   logic [llls_pkg::WEIGHT_W-1:0] job_weight;
   logic                          first_job;

   modport source (output valid, job_id, proc_time, deadline, job_weight, first_job,
                   input ready);
   modport sink   (input valid, job_id, proc_time, deadline, job_weight, first_job,
                   output ready);
endinterface

interface llls_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [llls_pkg::JOB_ID_W-1:0]  job_id_out;
   logic [llls_pkg::IDX_OUT_W-1:0] machine_index;
   logic [llls_pkg::TIME_W-1:0]    completion;
   logic [llls_pkg::TARD_W-1:0]    job_tardiness;
   logic [llls_pkg::TOTAL_W-1:0]   total_tardiness;

   modport source (output valid, job_id_out, machine_index, completion, job_tardiness,
                   total_tardiness, input ready);
   modport sink   (input valid, job_id_out, machine_index, completion, job_tardiness,
                   total_tardiness, output ready);
endinterface

`default_nettype wire

@@ hdl/least_loaded_list_scheduler.sv @@
// Each accepted request runs the sequencer steps INIT, SCAN, ADD, DIFF, MUL, ACC
//   and OUT before the response is loaded; OUT holds while a response waits.
// Jobs are taken one at a time, paced by the
//   one-machine-per-cycle load scan of the microcoded sequencer.
// The response register lets the next job enter while a result waits.
// Synchronous active-high reset: all loads and totals zero, machines_in_use 8.
// ---------------------------------------------------------------------------
// least_loaded_list_scheduler: microcoded least-loaded job placement
// Assigns each job to the least-loaded machine and tracks weighted tardiness.
// ---------------------------------------------------------------------------
`default_nettype none

module least_loaded_list_scheduler (
   input  wire logic                        clock,
   input  wire logic                        reset,
   llls_req_if.sink                         req_ch,
   llls_rsp_if.source                       rsp_ch,
   input  wire logic                        csr_wr_en,
   input  wire logic [llls_pkg::CFG_W-1:0]  csr_wr_data
);

   localparam int SEL_W = (llls_pkg::MACH_CNT_W > llls_pkg::CFG_W) ?
                          llls_pkg::MACH_CNT_W : llls_pkg::CFG_W;
   localparam logic [llls_pkg::TIME_W-1:0]  LOAD_MAX  = '1;
   localparam logic [llls_pkg::TOTAL_W-1:0] TOTAL_MAX = '1;

   llls_pkg::ctrl_word_type   cw;
   llls_pkg::step_type        pc_ff, pc_in;

   logic [llls_pkg::CFG_W-1:0]      cfg_ff;
   logic [llls_pkg::MACH_CNT_W-1:0] n_active;
   logic [SEL_W-1:0]                cfg_wide;

   logic [llls_pkg::TIME_W-1:0]  load_ff [llls_pkg::MAX_MACHINES];
   logic [llls_pkg::TOTAL_W-1:0] mtard_ff[llls_pkg::MAX_MACHINES];
   logic [llls_pkg::TOTAL_W-1:0] grand_ff;

   logic [llls_pkg::JOB_ID_W-1:0]   job_id_ff;
   logic [llls_pkg::PROC_W-1:0]     proc_ff;
   logic [llls_pkg::TIME_W-1:0]     due_ff;
   logic [llls_pkg::WEIGHT_W-1:0]   weight_ff;
   logic [llls_pkg::MACH_IDX_W-1:0] best_ff;
   logic [llls_pkg::TIME_W-1:0]     best_load_ff;
   logic [llls_pkg::MACH_CNT_W-1:0] idx_ff;
   logic [llls_pkg::TIME_W-1:0]     comp_ff;
   logic [llls_pkg::TIME_W-1:0]     diff_ff;
   logic [llls_pkg::TARD_W-1:0]     tard_ff;

   logic                            rsp_valid_ff;
   logic [llls_pkg::JOB_ID_W-1:0]   rsp_job_id_ff;
   logic [llls_pkg::IDX_OUT_W-1:0]  rsp_index_ff;
   logic [llls_pkg::TIME_W-1:0]     rsp_comp_ff;
   logic [llls_pkg::TARD_W-1:0]     rsp_tard_ff;
   logic [llls_pkg::TOTAL_W-1:0]    rsp_total_ff;

   logic                          req_take;
   logic                          rsp_busy;
   logic                          scan_valid;
   logic                          take_jump;
   logic [llls_pkg::TIME_W-1:0]   scan_load;
   logic [llls_pkg::TIME_W:0]     sum_wide;
   logic [llls_pkg::TARD_W-1:0]   prod;

   function automatic logic [llls_pkg::TOTAL_W-1:0] sat_add(
      input logic [llls_pkg::TOTAL_W-1:0] a,
      input logic [llls_pkg::TOTAL_W-1:0] b
   );
      logic [llls_pkg::TOTAL_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[llls_pkg::TOTAL_W] ? TOTAL_MAX : s[llls_pkg::TOTAL_W-1:0];
   endfunction

   assign cw = llls_pkg::ucode_rom(pc_ff);

   // clamp machines_in_use to 1..MAX_MACHINES
   always_comb begin
      cfg_wide = SEL_W'(cfg_ff);
      if (cfg_ff == '0) begin
         n_active = llls_pkg::MACH_CNT_W'(1);
      end else if (cfg_wide > SEL_W'(llls_pkg::MAX_MACHINES)) begin
         n_active = llls_pkg::MACH_CNT_W'(llls_pkg::MAX_MACHINES);
      end else begin
         n_active = llls_pkg::MACH_CNT_W'(cfg_wide);
      end
   end

   assign req_take   = cw.req_ready && req_ch.valid;
   assign rsp_busy   = rsp_valid_ff && !rsp_ch.ready;
   assign scan_valid = idx_ff < n_active;
   assign scan_load  = load_ff[idx_ff[llls_pkg::MACH_IDX_W-1:0]];
   assign sum_wide   = {1'b0, best_load_ff} + (llls_pkg::TIME_W + 1)'(proc_ff);
   assign prod       = llls_pkg::TARD_W'(diff_ff) * llls_pkg::TARD_W'(weight_ff);

   always_comb begin
      case (cw.cond)
         llls_pkg::JMP_NEVER:     take_jump = 1'b0;
         llls_pkg::JMP_NO_REQ:    take_jump = !req_ch.valid;
         llls_pkg::JMP_SCAN_MORE: take_jump = (idx_ff + 1'b1) < n_active;
         llls_pkg::JMP_RSP_BUSY:  take_jump = rsp_busy;
         default:                 take_jump = 1'b0;
      endcase
      pc_in = take_jump ? cw.target : pc_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= llls_pkg::STEP_WAIT;
         cfg_ff       <= llls_pkg::CFG_RESET;
         rsp_valid_ff <= 1'b0;
         grand_ff     <= '0;
         for (int i = 0; i < llls_pkg::MAX_MACHINES; i++) begin
            load_ff[i]  <= '0;
            mtard_ff[i] <= '0;
         end
      end else begin
         pc_ff <= pc_in;
         if (csr_wr_en) begin
            cfg_ff <= csr_wr_data;
         end
         if (cw.out_load && !rsp_busy) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (req_take && req_ch.first_job) begin
            grand_ff <= '0;
            for (int i = 0; i < llls_pkg::MAX_MACHINES; i++) begin
               load_ff[i]  <= '0;
               mtard_ff[i] <= '0;
            end
         end
         if (cw.add_load) begin
            load_ff[best_ff] <= sum_wide[llls_pkg::TIME_W] ? LOAD_MAX :
                                sum_wide[llls_pkg::TIME_W-1:0];
         end
         if (cw.acc) begin
            mtard_ff[best_ff] <= sat_add(mtard_ff[best_ff], llls_pkg::TOTAL_W'(tard_ff));
            grand_ff          <= sat_add(grand_ff, llls_pkg::TOTAL_W'(tard_ff));
         end
      end
   end

   // datapath payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         job_id_ff <= req_ch.job_id;
         proc_ff   <= req_ch.proc_time;
         due_ff    <= req_ch.deadline;
         weight_ff <= req_ch.job_weight;
      end
      if (cw.scan_init) begin
         best_ff      <= '0;
         best_load_ff <= load_ff[0];
         idx_ff       <= llls_pkg::MACH_CNT_W'(1);
      end
      if (cw.scan_step) begin
         // strict less-than keeps the lowest index on ties
         if (scan_valid && (scan_load < best_load_ff)) begin
            best_ff      <= idx_ff[llls_pkg::MACH_IDX_W-1:0];
            best_load_ff <= scan_load;
         end
         idx_ff <= idx_ff + 1'b1;
      end
      if (cw.add_load) begin
         comp_ff <= sum_wide[llls_pkg::TIME_W] ? LOAD_MAX : sum_wide[llls_pkg::TIME_W-1:0];
      end
      if (cw.diff) begin
         diff_ff <= (comp_ff > due_ff) ? comp_ff - due_ff : '0;
      end
      if (cw.mul) begin
         // product of a 32-bit and a 16-bit value never exceeds 48 bits
         tard_ff <= prod;
      end
      if (cw.out_load && !rsp_busy) begin
         rsp_job_id_ff <= job_id_ff;
         rsp_index_ff  <= llls_pkg::IDX_OUT_W'(best_ff);
         rsp_comp_ff   <= comp_ff;
         rsp_tard_ff   <= tard_ff;
         rsp_total_ff  <= grand_ff;
      end
   end

   assign req_ch.ready           = cw.req_ready;
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.job_id_out      = rsp_job_id_ff;
   assign rsp_ch.machine_index   = rsp_index_ff;
   assign rsp_ch.completion      = rsp_comp_ff;
   assign rsp_ch.job_tardiness   = rsp_tard_ff;
   assign rsp_ch.total_tardiness = rsp_total_ff;

`ifndef SYNTH
   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (pc_ff == llls_pkg::STEP_INIT))
      else $error("accepted transaction did not start the scan");

   a_best_load_tracks: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == llls_pkg::STEP_ADD) |-> (best_load_ff == load_ff[best_ff]))
      else $error("held minimum load differs from the chosen machine's load");

   a_scan_bounded: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == llls_pkg::STEP_SCAN) |->
         (idx_ff <= llls_pkg::MACH_CNT_W'(llls_pkg::MAX_MACHINES)))
      else $error("scan index ran past the machine array");

   a_total_monotone: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == llls_pkg::STEP_ACC) |=> (grand_ff >= $past(grand_ff)))
      else $error("grand total decreased on accumulate");

   a_rsp_from_out_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(pc_ff) == llls_pkg::STEP_OUT))
      else $error("response raised outside the output step");
`endif

endmodule

`default_nettype wire
